// ----- rtl/efw_pkg.sv -----
// ----------------------------------------------------------------------------
// Exposure fusion weights package
// Shared constants, types and the well-exposedness curve table.
// ----------------------------------------------------------------------------
package efw_pkg;

    localparam int MAX_EXPOSURES    = 8;
    localparam int IDX_W            = $clog2(MAX_EXPOSURES);
    localparam int COUNT_W          = 4;
    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(3);
    localparam int WEIGHT_W         = 16;
    localparam int WEIGHT_FRAC_BITS = 16;
    localparam int SUM_W            = 19;
    localparam int PROD_W           = 2 * WEIGHT_W;
    localparam int FULL_W           = 3 * WEIGHT_W;
    // Dividend is weight scaled to Q0.16 plus half the sum for rounding.
    localparam int NUM_W            = WEIGHT_W + WEIGHT_FRAC_BITS + 1;
    // The weight never exceeds the sum, so the quotient stays at or below 1.0.
    localparam int QUO_W            = WEIGHT_FRAC_BITS + 1;
    localparam int REM_W            = SUM_W + 1;
    localparam int BITCNT_W         = $clog2(QUO_W);
    localparam int QUEUE_DEPTH      = 4;
    localparam int QPTR_W           = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W           = QPTR_W + 1;

    localparam logic [63:0] Q30_ONE  = 64'd1073741824;
    localparam logic [63:0] EXPO_DIV = 64'd20808;
    localparam int TAYLOR_TERMS      = 16;

    typedef logic [255:0][WEIGHT_W-1:0] rom_t;

    // One exposure weight on its way from the front end to the back end.
    typedef struct packed {
        logic [WEIGHT_W-1:0] weight;
        logic [IDX_W-1:0]    index;
        logic                last;
    } wt_item_t;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
    } q_status_t;

    typedef struct packed {
        logic busy;
    } bk_status_t;

    typedef enum logic [1:0] {
        BK_ACCUM,
        BK_LOAD,
        BK_DIV,
        BK_PUT
    } back_state_t;

    function automatic logic [63:0] div_small(input logic [63:0] x, input int k);
        logic [63:0] r;
        case (k)
            2:       r = x / 2;
            3:       r = x / 3;
            4:       r = x / 4;
            5:       r = x / 5;
            6:       r = x / 6;
            7:       r = x / 7;
            8:       r = x / 8;
            9:       r = x / 9;
            10:      r = x / 10;
            11:      r = x / 11;
            12:      r = x / 12;
            13:      r = x / 13;
            14:      r = x / 14;
            15:      r = x / 15;
            16:      r = x / 16;
            default: r = x;
        endcase
        return r;
    endfunction

    // exp(-(v/255-0.5)^2/0.08) in Q0.16: Taylor series of exp(-x/8), squared
    // three times.
    function automatic logic [WEIGHT_W-1:0] rom_entry(input int v);
        longint      d;
        logic [63:0] dd;
        logic [63:0] y;
        logic [63:0] term;
        logic [63:0] e;
        logic [63:0] q;
        longint      acc;
        d    = 2 * longint'(v) - 255;
        dd   = d * d;
        y    = ((dd << 30) / EXPO_DIV) >> 3;
        term = Q30_ONE;
        acc  = longint'(Q30_ONE);
        for (int k = 1; k <= TAYLOR_TERMS; k++) begin
            term = div_small((term * y) >> 30, k);
            if ((k % 2) == 1)
                acc = acc - longint'(term);
            else
                acc = acc + longint'(term);
        end
        if (acc < 0)
            acc = 0;
        e = acc;
        for (int s = 0; s < 3; s++)
            e = (e * e + (Q30_ONE >> 1)) >> 30;
        q = (e + 64'd8192) >> 14;
        if (q > 64'd65535)
            q = 64'd65535;
        return q[WEIGHT_W-1:0];
    endfunction

    function automatic rom_t build_rom();
        rom_t r;
        for (int v = 0; v < 256; v++)
            r[v] = rom_entry(v);
        return r;
    endfunction

    localparam rom_t EXPO_ROM = build_rom();

endpackage

// ----- rtl/efw_front.sv -----
// ----------------------------------------------------------------------------
// Exposure fusion weights front end
// Holds the exposure count, numbers the exposures of a position and computes
// each exposure's weight in a three-stage pipeline.
// ----------------------------------------------------------------------------
module efw_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr,
    input  logic [efw_pkg::COUNT_W-1:0]   cfg_count,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    red,
    input  logic [7:0]                    green,
    input  logic [7:0]                    blue,
    output logic                          out_valid,
    input  logic                          out_ready,
    output efw_pkg::wt_item_t             out_item
);

    logic [efw_pkg::COUNT_W-1:0]  count_reg;
    logic [efw_pkg::COUNT_W-1:0]  eff_count;
    logic [efw_pkg::IDX_W-1:0]    seen_reg;
    logic [efw_pkg::IDX_W-1:0]    seen_next;
    logic [efw_pkg::IDX_W:0]      seen_plus;
    logic                         is_last;
    logic                         advance;
    logic                         accept;

    logic                         s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic [efw_pkg::WEIGHT_W-1:0] s1_er_reg, s1_eg_reg, s1_eb_reg;
    logic [efw_pkg::IDX_W-1:0]    s1_idx_reg, s2_idx_reg;
    logic                         s1_last_reg, s2_last_reg;
    logic [efw_pkg::PROD_W-1:0]   s2_prod_reg;
    logic [efw_pkg::WEIGHT_W-1:0] s2_eb_reg;
    logic [efw_pkg::FULL_W-1:0]   full_prod;
    logic [efw_pkg::FULL_W:0]     rounded;
    logic [efw_pkg::WEIGHT_W:0]   weight_wide;
    logic [efw_pkg::WEIGHT_W-1:0] weight_next;
    efw_pkg::wt_item_t            s3_item_reg;

    // The whole pipeline stalls when its last stage cannot move on.
    assign advance  = !s3_valid_reg || out_ready;
    assign in_ready = advance;
    assign accept   = in_valid && advance;

    always_comb
    begin
        if (count_reg == '0)
            eff_count = efw_pkg::COUNT_W'(1);
        else if (count_reg > efw_pkg::COUNT_W'(efw_pkg::MAX_EXPOSURES))
            eff_count = efw_pkg::COUNT_W'(efw_pkg::MAX_EXPOSURES);
        else
            eff_count = count_reg;
    end

    assign seen_plus = (efw_pkg::IDX_W + 1)'(seen_reg) + (efw_pkg::IDX_W + 1)'(1);
    assign is_last   = efw_pkg::COUNT_W'(seen_plus) >= eff_count;
    assign seen_next = is_last ? '0 : seen_plus[efw_pkg::IDX_W-1:0];

    assign full_prod   = efw_pkg::FULL_W'(s2_prod_reg) * efw_pkg::FULL_W'(s2_eb_reg);
    assign rounded     = (efw_pkg::FULL_W + 1)'(full_prod)
                         + ((efw_pkg::FULL_W + 1)'(1) << (efw_pkg::PROD_W - 1));
    assign weight_wide = rounded[efw_pkg::FULL_W:efw_pkg::PROD_W];
    assign weight_next = weight_wide[efw_pkg::WEIGHT_W] ? '1
                         : weight_wide[efw_pkg::WEIGHT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= efw_pkg::COUNT_RESET;
            seen_reg     <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
                count_reg <= cfg_count;
            if (accept)
                seen_reg <= seen_next;
            if (advance)
            begin
                s1_valid_reg <= in_valid;
                s2_valid_reg <= s1_valid_reg;
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_er_reg          <= efw_pkg::EXPO_ROM[red];
            s1_eg_reg          <= efw_pkg::EXPO_ROM[green];
            s1_eb_reg          <= efw_pkg::EXPO_ROM[blue];
            s1_idx_reg         <= seen_reg;
            s1_last_reg        <= is_last;
            s2_prod_reg        <= efw_pkg::PROD_W'(s1_er_reg) * efw_pkg::PROD_W'(s1_eg_reg);
            s2_eb_reg          <= s1_eb_reg;
            s2_idx_reg         <= s1_idx_reg;
            s2_last_reg        <= s1_last_reg;
            s3_item_reg.weight <= weight_next;
            s3_item_reg.index  <= s2_idx_reg;
            s3_item_reg.last   <= s2_last_reg;
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_item  = s3_item_reg;

endmodule

// ----- rtl/efw_queue.sv -----
// ----------------------------------------------------------------------------
// Exposure fusion weights queue
// Small first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module efw_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  efw_pkg::wt_item_t    in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output efw_pkg::wt_item_t    out_item,
    output efw_pkg::q_status_t   status
);

    efw_pkg::wt_item_t           mem_reg [efw_pkg::QUEUE_DEPTH];
    logic [efw_pkg::QPTR_W-1:0]  wr_ptr_reg;
    logic [efw_pkg::QPTR_W-1:0]  rd_ptr_reg;
    logic [efw_pkg::QCNT_W-1:0]  count_reg;
    logic [efw_pkg::QCNT_W-1:0]  count_next;
    logic                        push;
    logic                        pop;

    assign in_ready  = count_reg != efw_pkg::QCNT_W'(efw_pkg::QUEUE_DEPTH);
    assign out_valid = count_reg != '0;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + efw_pkg::QCNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - efw_pkg::QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + efw_pkg::QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + efw_pkg::QPTR_W'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= in_item;
    end

    assign status.count = count_reg;

endmodule

// ----- rtl/efw_back.sv -----
// ----------------------------------------------------------------------------
// Exposure fusion weights back end
// Stores the weights of a position and their sum, then normalizes each weight
// with a bit-serial divider and hands it to the output register.
// ----------------------------------------------------------------------------
module efw_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  efw_pkg::wt_item_t             in_item,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [efw_pkg::WEIGHT_W-1:0]  norm_weight,
    output logic [efw_pkg::IDX_W-1:0]     exposure_index,
    output logic                          last_weight,
    output efw_pkg::bk_status_t           status
);

    efw_pkg::back_state_t          state_reg, state_next;

    logic [efw_pkg::WEIGHT_W-1:0]  store_reg [efw_pkg::MAX_EXPOSURES];
    logic [efw_pkg::SUM_W-1:0]     sum_reg;
    logic [efw_pkg::IDX_W-1:0]     last_idx_reg;
    logic [efw_pkg::IDX_W-1:0]     k_reg;
    logic [efw_pkg::REM_W-1:0]     rem_reg;
    logic [efw_pkg::QUO_W-1:0]     shift_reg;
    logic [efw_pkg::QUO_W-1:0]     quo_reg;
    logic [efw_pkg::BITCNT_W-1:0]  bit_cnt_reg;
    logic [efw_pkg::WEIGHT_W-1:0]  out_weight_reg;
    logic [efw_pkg::IDX_W-1:0]     out_index_reg;
    logic                          out_last_reg;
    logic                          out_valid_reg;

    logic                          take;
    logic                          put;
    logic                          div_done;
    logic                          k_is_last;
    logic [efw_pkg::NUM_W-1:0]     num;
    logic [efw_pkg::REM_W-1:0]     trial;
    logic                          fits;
    logic [efw_pkg::WEIGHT_W-1:0]  result;

    assign take      = in_valid && in_ready;
    assign div_done  = bit_cnt_reg == efw_pkg::BITCNT_W'(efw_pkg::QUO_W - 1);
    assign k_is_last = k_reg == last_idx_reg;
    assign put       = (state_reg == efw_pkg::BK_PUT) && (!out_valid_reg || out_ready);

    assign num = {store_reg[k_reg], {efw_pkg::WEIGHT_FRAC_BITS{1'b0}}}
                 + efw_pkg::NUM_W'(sum_reg >> 1);
    assign trial = {rem_reg[efw_pkg::REM_W-2:0], shift_reg[efw_pkg::QUO_W-1]};
    assign fits  = trial >= efw_pkg::REM_W'(sum_reg);

    // A quotient of exactly 1.0 saturates; an all-zero position gives zeros.
    always_comb
    begin
        if (sum_reg == '0)
            result = '0;
        else if (quo_reg[efw_pkg::QUO_W-1])
            result = '1;
        else
            result = quo_reg[efw_pkg::WEIGHT_W-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            efw_pkg::BK_ACCUM:
                if (take && in_item.last)
                    state_next = efw_pkg::BK_LOAD;
            efw_pkg::BK_LOAD:
                state_next = efw_pkg::BK_DIV;
            efw_pkg::BK_DIV:
                if (div_done)
                    state_next = efw_pkg::BK_PUT;
            efw_pkg::BK_PUT:
                if (put)
                    state_next = k_is_last ? efw_pkg::BK_ACCUM : efw_pkg::BK_LOAD;
            default:
                state_next = efw_pkg::BK_ACCUM;
        endcase
    end

    always_comb
    begin
        in_ready    = state_reg == efw_pkg::BK_ACCUM;
        status.busy = state_reg != efw_pkg::BK_ACCUM;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= efw_pkg::BK_ACCUM;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (take)
                sum_reg <= sum_reg + efw_pkg::SUM_W'(in_item.weight);
            else if (put && k_is_last)
                sum_reg <= '0;
            if (put)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            store_reg[in_item.index] <= in_item.weight;
            last_idx_reg             <= in_item.index;
            k_reg                    <= '0;
        end
        case (state_reg)
            efw_pkg::BK_LOAD:
            begin
                // The top dividend bits are already below the sum.
                rem_reg     <= efw_pkg::REM_W'(num[efw_pkg::NUM_W-1:efw_pkg::QUO_W]);
                shift_reg   <= num[efw_pkg::QUO_W-1:0];
                bit_cnt_reg <= '0;
            end
            efw_pkg::BK_DIV:
            begin
                rem_reg     <= fits ? trial - efw_pkg::REM_W'(sum_reg) : trial;
                quo_reg     <= {quo_reg[efw_pkg::QUO_W-2:0], fits};
                shift_reg   <= shift_reg << 1;
                bit_cnt_reg <= bit_cnt_reg + efw_pkg::BITCNT_W'(1);
            end
            efw_pkg::BK_PUT:
                if (put)
                begin
                    out_weight_reg <= result;
                    out_index_reg  <= k_reg;
                    out_last_reg   <= k_is_last;
                    k_reg          <= k_reg + efw_pkg::IDX_W'(1);
                end
            default:
            begin
            end
        endcase
    end

    assign out_valid      = out_valid_reg;
    assign norm_weight    = out_weight_reg;
    assign exposure_index = out_index_reg;
    assign last_weight    = out_last_reg;

endmodule

// ----- rtl/exposure_fusion_weights_top.sv -----
// ----------------------------------------------------------------------------
// Exposure fusion weights
// Well-exposedness weights of a pixel position, normalized over its exposures.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid/in_ready) takes one exposure's RGB pixel
// per item, all exposures of a position back to back. The configuration
// channel (cfg_valid/cfg_ready) writes exposure_count, the number of
// exposures per position; it is always ready and should be written only while
// the block is idle. It resets to 3.
// The output channel (out_valid/out_ready) gives one normalized weight per
// exposure, in exposure order, after the last exposure of a position arrives.
// Timing: a pixel passes the weight pipeline and the queue before the back end
// takes it. Each normalized weight comes from the one-bit-per-cycle divider
// (a load step, 17 quotient bits, a hand-off step). Pixels are taken one per
// cycle until the four-entry queue and the weight pipeline fill; the back end
// takes no new weights while it normalizes a position.
// Reset clears the pipeline, the queue, the running sum and the exposure
// counter. When the receiver stalls, the result holds in the output register,
// the divider waits, and input keeps flowing until the queue and the pipeline
// are full.
// ----------------------------------------------------------------------------
module exposure_fusion_weights_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [efw_pkg::COUNT_W-1:0]   exposure_count,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    red,
    input  logic [7:0]                    green,
    input  logic [7:0]                    blue,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [15:0]                   norm_weight,
    output logic [2:0]                    exposure_index,
    output logic                          last_weight
);

    logic                 fr_valid;
    logic                 fr_ready;
    efw_pkg::wt_item_t    fr_item;
    logic                 q_valid;
    logic                 q_ready;
    efw_pkg::wt_item_t    q_item;
    efw_pkg::q_status_t   q_stat;
    efw_pkg::bk_status_t  bk_stat;

    assign cfg_ready = 1'b1;

    efw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_count (exposure_count),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .out_valid (fr_valid),
        .out_ready (fr_ready),
        .out_item  (fr_item)
    );

    efw_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_item   (fr_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item),
        .status    (q_stat)
    );

    efw_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (q_valid),
        .in_ready       (q_ready),
        .in_item        (q_item),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .norm_weight    (norm_weight),
        .exposure_index (exposure_index),
        .last_weight    (last_weight),
        .status         (bk_stat)
    );

    // A new result only appears after the back end has worked on it.
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(bk_stat.busy))
        else $error("result appeared without back-end work");

    // While a weight other than the last waits, the position is not finished.
    a_position_open: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_weight |-> bk_stat.busy)
        else $error("back end left a position before its last weight");

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.count <= efw_pkg::QCNT_W'(efw_pkg::QUEUE_DEPTH))
        else $error("queue occupancy out of range");

endmodule
